FILE: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

	localparam int DIV_STAGES = 64;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP      = 3'd0;
	localparam logic [2:0] REG_PRESS_LO  = 3'd1;
	localparam logic [2:0] REG_PRESS_HI  = 3'd2;
	localparam logic [2:0] REG_PRESS_HUM = 3'd3;
	localparam logic [2:0] REG_HUM_TAIL  = 3'd4;

	localparam logic [32:0] TF_PRESS_OFFSET = 33'd128000;
	localparam logic [20:0] PRESS_BASE      = 21'd1048576;
	localparam logic [63:0] PRESS_SCALE     = 64'd3125;
	localparam logic [31:0] TF_HUM_OFFSET   = 32'd76800;
	localparam logic [31:0] HUM_ROUND_A     = 32'd16384;
	localparam logic [31:0] HUM_BIAS_B      = 32'd2097152;
	localparam logic [31:0] HUM_BIAS_C      = 32'd32768;
	localparam logic [31:0] HUM_ROUND_D     = 32'd8192;
	localparam logic [31:0] HUM_MAX         = 32'd419430400;
	localparam logic [63:0] PRESS_BIAS      = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0]  h6;
	} coef_t;

	// one item inside the divider
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] dq;
		logic [63:0] mb;
		logic        neg;
		logic        inval;
		logic [31:0] temp;
		logic [16:0] hum;
	} div_t;

endpackage

`default_nettype wire

FILE: hdl/esc_temp.sv
// ----------------------------------------------------------------------------
// esc_temp
// Four-stage fine temperature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_temp
	import esc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire coef_t       coef,
	input  wire logic        vld_in,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	input  wire logic [15:0] raw_humidity,
	output logic             vld_out,
	output logic [31:0]      tfine,
	output logic [19:0]      rawp_out,
	output logic [15:0]      rawh_out
);

	logic [31:0] t2x, t3x;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [31:0] d3_s1, d4_s1, m1_s2, m2_s2, tv1_s3, m3_s3, tfine_s4;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3, rawp_s4;
	logic [15:0] rawh_s1, rawh_s2, rawh_s3, rawh_s4;
	logic [31:0] a_3;

	assign t2x = {{16{coef.t2[15]}}, coef.t2};
	assign t3x = {{16{coef.t3[15]}}, coef.t3};
	assign a_3 = $signed(m2_s2) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d3_s1    <= {15'b0, raw_temperature[19:3]} - {15'b0, coef.t1, 1'b0};
			d4_s1    <= {16'b0, raw_temperature[19:4]} - {16'b0, coef.t1};
			rawp_s1  <= raw_pressure;
			rawh_s1  <= raw_humidity;
			m1_s2    <= d3_s1 * t2x;
			m2_s2    <= d4_s1 * d4_s1;
			rawp_s2  <= rawp_s1;
			rawh_s2  <= rawh_s1;
			tv1_s3   <= $signed(m1_s2) >>> 11;
			m3_s3    <= a_3 * t3x;
			rawp_s3  <= rawp_s2;
			rawh_s3  <= rawh_s2;
			tfine_s4 <= tv1_s3 + 32'($signed(m3_s3) >>> 14);
			rawp_s4  <= rawp_s3;
			rawh_s4  <= rawh_s3;
		end
	end

	assign vld_out  = vld_s4;
	assign tfine    = tfine_s4;
	assign rawp_out = rawp_s4;
	assign rawh_out = rawh_s4;

endmodule

`default_nettype wire

FILE: hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Eight-stage pressure pre-division and humidity pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_front
	import esc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire coef_t       coef,
	input  wire logic        vld_in,
	input  wire logic [31:0] tfine,
	input  wire logic [19:0] rawp,
	input  wire logic [15:0] rawh,
	output logic             vld_out,
	output div_t             div_out
);

	logic [7:0]  vld_s;
	logic [31:0] tmul;

	// stage 1
	logic [32:0] v1_s1;
	logic [31:0] temp_s1, hv_s1;
	logic [20:0] pp_s1;
	logic [15:0] rawh_s1;
	// stage 2
	logic signed [65:0] sq_full;
	logic signed [48:0] a5_full, a2_full;
	logic [63:0] sq_s2;
	logic [48:0] a5_s2, a2_s2;
	logic [20:0] pp_s2;
	logic [31:0] hapre_s2, hm6_s2, hm3_s2;
	// stage 3
	logic [63:0] x6_s3, x3_s3;
	logic [48:0] a5_s3, a2_s3;
	logic [20:0] pp_s3;
	logic [31:0] ha_s3, hi_s3;
	logic [31:0] hm6_sh, hm3_sh;
	// stage 4
	logic [63:0] v2_s4, v1b_s4;
	logic [20:0] pp_s4;
	logic [31:0] ha_s4, hbpre_s4;
	// stage 5
	logic [63:0] m_s5, v2_s5;
	logic [20:0] pp_s5;
	logic [31:0] hvv_s5, hb_5;
	// stage 6
	logic [63:0] v1c_s6, t_s6;
	logic [31:0] hvv_s6, s2_s6, hs_6;
	// stage 7
	logic [63:0] n_s7, v1c_s7;
	logic        inval_s7;
	logic [31:0] hvv_s7, hx_s7, s2_sh;
	// stage 8
	div_t        d_s8;
	logic [31:0] hr_8;
	logic [16:0] hum_8;

	logic [31:0] temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;

	assign tmul    = tfine * 32'd5 + 32'd128;
	assign sq_full = $signed(v1_s1) * $signed(v1_s1);
	assign a5_full = $signed(v1_s1) * $signed(coef.p5);
	assign a2_full = $signed(v1_s1) * $signed(coef.p2);
	assign hm6_sh  = $signed(hm6_s2) >>> 10;
	assign hm3_sh  = 32'($signed(hm3_s2) >>> 11) + HUM_BIAS_C;
	assign hb_5    = $signed(hbpre_s4) >>> 14;
	assign hs_6    = $signed(hvv_s5) >>> 15;
	assign s2_sh   = $signed(s2_s6) >>> 7;
	assign hr_8    = hvv_s7 - 32'($signed(hx_s7) >>> 4);

	// clamp to 0..100 percent
	always_comb begin
		if (hr_8[31]) begin
			hum_8 = 17'd0;
		end else if (hr_8 > HUM_MAX) begin
			hum_8 = HUM_MAX[28:12];
		end else begin
			hum_8 = hr_8[28:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[6:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s1    <= {tfine[31], tfine} - TF_PRESS_OFFSET;
			temp_s1  <= $signed(tmul) >>> 8;
			hv_s1    <= tfine - TF_HUM_OFFSET;
			pp_s1    <= PRESS_BASE - {1'b0, rawp};
			rawh_s1  <= rawh;

			sq_s2    <= sq_full[63:0];
			a5_s2    <= a5_full;
			a2_s2    <= a2_full;
			pp_s2    <= pp_s1;
			temp_s2  <= temp_s1;
			hapre_s2 <= {2'b0, rawh_s1, 14'b0} - {coef.h4[11:0], 20'b0}
				- {{16{coef.h5[15]}}, coef.h5} * hv_s1 + HUM_ROUND_A;
			hm6_s2   <= hv_s1 * {{24{coef.h6[7]}}, coef.h6};
			hm3_s2   <= hv_s1 * {24'b0, coef.h3};

			x6_s3    <= sq_s2 * {{48{coef.p6[15]}}, coef.p6};
			x3_s3    <= sq_s2 * {{48{coef.p3[15]}}, coef.p3};
			a5_s3    <= a5_s2;
			a2_s3    <= a2_s2;
			pp_s3    <= pp_s2;
			temp_s3  <= temp_s2;
			ha_s3    <= $signed(hapre_s2) >>> 15;
			hi_s3    <= hm6_sh * hm3_sh;

			v2_s4    <= x6_s3 + {{15{a5_s3[48]}}, a5_s3[48:0]} * 64'd131072
				+ {{13{coef.p4[15]}}, coef.p4, 35'b0};
			v1b_s4   <= 64'($signed(x3_s3) >>> 8) + {{3{a2_s3[48]}}, a2_s3, 12'b0};
			pp_s4    <= pp_s3;
			temp_s4  <= temp_s3;
			ha_s4    <= ha_s3;
			hbpre_s4 <= (32'($signed(hi_s3) >>> 10) + HUM_BIAS_B)
				* {{16{coef.h2[15]}}, coef.h2} + HUM_ROUND_D;

			m_s5     <= (PRESS_BIAS + v1b_s4) * {48'b0, coef.p1};
			v2_s5    <= v2_s4;
			pp_s5    <= pp_s4;
			temp_s5  <= temp_s4;
			hvv_s5   <= ha_s4 * hb_5;

			v1c_s6   <= $signed(m_s5) >>> 33;
			t_s6     <= {12'b0, pp_s5, 31'b0} - v2_s5;
			temp_s6  <= temp_s5;
			hvv_s6   <= hvv_s5;
			s2_s6    <= hs_6 * hs_6;

			n_s7     <= t_s6 * PRESS_SCALE;
			v1c_s7   <= v1c_s6;
			inval_s7 <= (v1c_s6 == 64'd0);
			temp_s7  <= temp_s6;
			hvv_s7   <= hvv_s6;
			hx_s7    <= s2_sh * {24'b0, coef.h1};

			d_s8.rem   <= 64'd0;
			d_s8.dq    <= n_s7[63] ? (64'd0 - n_s7) : n_s7;
			d_s8.mb    <= v1c_s7[63] ? (64'd0 - v1c_s7) : v1c_s7;
			d_s8.neg   <= n_s7[63] ^ v1c_s7[63];
			d_s8.inval <= inval_s7;
			d_s8.temp  <= temp_s7;
			d_s8.hum   <= hum_8;
		end
	end

	assign vld_out = vld_s[7];
	assign div_out = d_s8;

endmodule

`default_nettype wire

FILE: hdl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div
	import esc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic vld_in,
	input  wire div_t div_in,
	output logic      vld_out,
	output div_t      div_out
);

	div_t stage_s [DIV_STAGES];
	logic vld_s   [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		div_t        prv;
		div_t        nxt;
		logic        pv;
		logic [63:0] sh;
		logic        ge;

		if (i == 0) begin : g_first
			assign prv = div_in;
			assign pv  = vld_in;
		end else begin : g_next
			assign prv = stage_s[i-1];
			assign pv  = vld_s[i-1];
		end

		// remainder stays below the divisor, so its top bit is free
		assign sh = {prv.rem[62:0], prv.dq[63]};
		assign ge = (sh >= prv.mb);

		always_comb begin
			nxt     = prv;
			nxt.rem = ge ? (sh - prv.mb) : sh;
			nxt.dq  = {prv.dq[62:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[i] <= nxt;
			end
		end
	end

	assign vld_out = vld_s[DIV_STAGES-1];
	assign div_out = stage_s[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/esc_post.sv
// ----------------------------------------------------------------------------
// esc_post
// Five-stage pressure correction after the division; last stage is the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_post
	import esc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire coef_t coef,
	input  wire logic  vld_in,
	input  wire div_t  div_in,
	output logic              vld_out,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_invalid,
	output logic [16:0]        humidity_q22_10
);

	logic [4:0]  vld_s;
	logic [63:0] p_s1, p_s2, p_s3, p_s4;
	logic [63:0] q_s2, y_s2, z_s2, z_s3;
	logic [63:0] mll_s3;
	logic [31:0] mhl_s3, mlh_s3;
	logic [63:0] v1_s4, v2_s4, w_4, pr_5;
	logic [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5;
	logic [16:0] hum_s1, hum_s2, hum_s3, hum_s4, hum_s5;
	logic        inval_s1, inval_s2, inval_s3, inval_s4, inval_s5;
	logic [31:0] pres_s5;
	logic [63:0] psum_5;

	// low 64 bits of y * q from three 32-bit partial products
	assign w_4    = mll_s3 + {mhl_s3 + mlh_s3, 32'b0};
	assign psum_5 = p_s4 + v1_s4 + v2_s4;
	assign pr_5   = 64'($signed(psum_5) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[3:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1     <= div_in.neg ? (64'd0 - div_in.dq) : div_in.dq;
			temp_s1  <= div_in.temp;
			hum_s1   <= div_in.hum;
			inval_s1 <= div_in.inval;

			q_s2     <= $signed(p_s1) >>> 13;
			y_s2     <= 64'($signed(p_s1) >>> 13) * {{48{coef.p9[15]}}, coef.p9};
			z_s2     <= p_s1 * {{48{coef.p8[15]}}, coef.p8};
			p_s2     <= p_s1;
			temp_s2  <= temp_s1;
			hum_s2   <= hum_s1;
			inval_s2 <= inval_s1;

			mll_s3   <= {32'b0, y_s2[31:0]} * {32'b0, q_s2[31:0]};
			mhl_s3   <= y_s2[63:32] * q_s2[31:0];
			mlh_s3   <= y_s2[31:0] * q_s2[63:32];
			z_s3     <= z_s2;
			p_s3     <= p_s2;
			temp_s3  <= temp_s2;
			hum_s3   <= hum_s2;
			inval_s3 <= inval_s2;

			v1_s4    <= $signed(w_4) >>> 25;
			v2_s4    <= $signed(z_s3) >>> 19;
			p_s4     <= p_s3;
			temp_s4  <= temp_s3;
			hum_s4   <= hum_s3;
			inval_s4 <= inval_s3;

			pres_s5  <= inval_s4 ? 32'd0 : pr_5[31:0];
			temp_s5  <= temp_s4;
			hum_s5   <= hum_s4;
			inval_s5 <= inval_s4;
		end
	end

	assign vld_out           = vld_s[4];
	assign temperature_centi = temp_s5;
	assign pressure_q24_8    = pres_s5;
	assign pressure_invalid  = inval_s5;
	assign humidity_q22_10   = hum_s5;

endmodule

`default_nettype wire

FILE: hdl/environmental_sensor_compensation.sv
// ----------------------------------------------------------------------------
// environmental_sensor_compensation
// Fixed-point temperature, pressure and humidity compensation of raw bursts.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    raw_temperature, raw_pressure,
//                                             raw_humidity
// out       output     out_valid / out_stall  temperature_centi, pressure_q24_8,
//                                             pressure_invalid, humidity_q22_10
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one item per cycle while out_stall does not hold the pipeline; stages: 4 temperature,
// 8 pre-division, 64 divider stages at one quotient bit each, 5 post-division
// the whole pipeline holds while a result waits and out_stall is high;
// in_stall follows that condition, so nothing is dropped or repeated
// reset clears the valid bits and the coefficient registers
// ----------------------------------------------------------------------------
`default_nettype none

module environmental_sensor_compensation
	import esc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	input  wire logic [15:0] raw_humidity,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic             pressure_invalid,
	output logic [16:0]      humidity_q22_10,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [47:0] temp_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [47:0] ph_q;
	logic [39:0] htail_q;
	coef_t       coef;
	logic        adv;

	logic        t_vld;
	logic [31:0] t_fine;
	logic [19:0] t_rawp;
	logic [15:0] t_rawh;
	logic        f_vld;
	div_t        f_div;
	logic        d_vld;
	div_t        d_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plo_q   <= '0;
			phi_q   <= '0;
			ph_q    <= '0;
			htail_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP:      temp_q  <= cfg_data[47:0];
				REG_PRESS_LO:  plo_q   <= cfg_data;
				REG_PRESS_HI:  phi_q   <= cfg_data;
				REG_PRESS_HUM: ph_q    <= cfg_data[47:0];
				REG_HUM_TAIL:  htail_q <= cfg_data[39:0];
				default: begin
				end
			endcase
		end
	end

	assign coef.t1 = temp_q[15:0];
	assign coef.t2 = temp_q[31:16];
	assign coef.t3 = temp_q[47:32];
	assign coef.p1 = plo_q[15:0];
	assign coef.p2 = plo_q[31:16];
	assign coef.p3 = plo_q[47:32];
	assign coef.p4 = plo_q[63:48];
	assign coef.p5 = phi_q[15:0];
	assign coef.p6 = phi_q[31:16];
	assign coef.p7 = phi_q[47:32];
	assign coef.p8 = phi_q[63:48];
	assign coef.p9 = ph_q[15:0];
	assign coef.h1 = ph_q[23:16];
	assign coef.h2 = ph_q[39:24];
	assign coef.h3 = ph_q[47:40];
	assign coef.h4 = htail_q[15:0];
	assign coef.h5 = htail_q[31:16];
	assign coef.h6 = htail_q[39:32];

	// whole pipeline moves unless the waiting result is held off
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	esc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.coef            (coef),
		.vld_in          (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.vld_out         (t_vld),
		.tfine           (t_fine),
		.rawp_out        (t_rawp),
		.rawh_out        (t_rawh)
	);

	esc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.coef    (coef),
		.vld_in  (t_vld),
		.tfine   (t_fine),
		.rawp    (t_rawp),
		.rawh    (t_rawh),
		.vld_out (f_vld),
		.div_out (f_div)
	);

	esc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (f_vld),
		.div_in  (f_div),
		.vld_out (d_vld),
		.div_out (d_div)
	);

	esc_post u_post (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.coef              (coef),
		.vld_in            (d_vld),
		.div_in            (d_div),
		.vld_out           (out_valid),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.pressure_invalid  (pressure_invalid),
		.humidity_q22_10   (humidity_q22_10)
	);

endmodule

`default_nettype wire
